[hw/rtl/cfgtok_pkg.sv]
package cfgtok_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int POS_W = 16;

	localparam logic [1:0] RK_LEX   = 2'd0;
	localparam logic [1:0] RK_TOKEN = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	localparam logic [3:0] TK_IDENT    = 4'd0;
	localparam logic [3:0] TK_DO       = 4'd1;
	localparam logic [3:0] TK_END      = 4'd2;
	localparam logic [3:0] TK_NUMBER   = 4'd3;
	localparam logic [3:0] TK_STRING   = 4'd4;
	localparam logic [3:0] TK_EQUAL    = 4'd5;
	localparam logic [3:0] TK_COMMA    = 4'd6;
	localparam logic [3:0] TK_DOT      = 4'd7;
	localparam logic [3:0] TK_LBRACKET = 4'd8;
	localparam logic [3:0] TK_RBRACKET = 4'd9;
	localparam logic [3:0] TK_EOF      = 4'd10;

	localparam logic [2:0] ER_UNTERM = 3'd0;
	localparam logic [2:0] ER_ESCAPE = 3'd1;
	localparam logic [2:0] ER_SQUOTE = 3'd2;
	localparam logic [2:0] ER_CHAR   = 3'd3;
	localparam logic [2:0] ER_NUMBER = 3'd4;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       lbyte;
		logic [3:0]       tok;
		logic [2:0]       err;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] col;
	} rec_t;

	typedef struct packed {
		logic [1:0]       cnt;
		rec_t [2:0]       recs;
	} bundle_t;

	function automatic rec_t mk_lex(input logic [7:0] b, input logic [POS_W-1:0] line,
			input logic [POS_W-1:0] col);
		rec_t r;
		r       = '0;
		r.kind  = RK_LEX;
		r.lbyte = b;
		r.line  = line;
		r.col   = col;
		return r;
	endfunction

	function automatic rec_t mk_tok(input logic [3:0] t, input logic [POS_W-1:0] line,
			input logic [POS_W-1:0] col);
		rec_t r;
		r      = '0;
		r.kind = RK_TOKEN;
		r.tok  = t;
		r.line = line;
		r.col  = col;
		return r;
	endfunction

	function automatic rec_t mk_err(input logic [2:0] e, input logic [POS_W-1:0] line,
			input logic [POS_W-1:0] col);
		rec_t r;
		r      = '0;
		r.kind = RK_ERROR;
		r.err  = e;
		r.line = line;
		r.col  = col;
		return r;
	endfunction

endpackage

[hw/rtl/cfgtok_front.sv]
module cfgtok_front #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           text_byte,
	input  logic                 is_end,
	input  logic                 full,
	output logic                 push_valid,
	output cfgtok_pkg::bundle_t  push_data
);
	import cfgtok_pkg::*;

	localparam logic [3:0] MD_IDLE     = 4'd0;
	localparam logic [3:0] MD_COMMENT  = 4'd1;
	localparam logic [3:0] MD_IDENT    = 4'd2;
	localparam logic [3:0] MD_NUM_INT  = 4'd3;
	localparam logic [3:0] MD_NUM_DOT  = 4'd4;
	localparam logic [3:0] MD_NUM_FRAC = 4'd5;
	localparam logic [3:0] MD_STR      = 4'd6;
	localparam logic [3:0] MD_STR_ESC  = 4'd7;
	localparam logic [3:0] MD_DONE     = 4'd8;
	localparam logic [3:0] MD_ERROR    = 4'd9;

	localparam logic [2:0] KW_NONE = 3'd0;
	localparam logic [2:0] KW_D    = 3'd1;
	localparam logic [2:0] KW_DO   = 3'd2;
	localparam logic [2:0] KW_E    = 3'd3;
	localparam logic [2:0] KW_EN   = 3'd4;
	localparam logic [2:0] KW_END  = 3'd5;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	logic [3:0]             mode_q, mode_d;
	logic [2:0]             kw_q, kw_d;
	logic [LINE_BITS-1:0]   cur_line_q, tok_line_q, tok_line_d;
	logic [COLUMN_BITS-1:0] cur_col_q, tok_col_q, tok_col_d;

	logic                   acc, adv, do_idle;
	logic                   is_dig, is_alpha, id_start, id_char, is_blank, is_punct;
	logic [3:0]             punct_tok, kw_tok;
	logic [2:0]             kw_step;
	logic [POS_W-1:0]       cl16, cc16, tl16, tc16;
	rec_t                   p, m1, m2;
	logic                   p_en, m1_en, m2_en;

	assign acc = in_valid & ~full;

	assign cl16 = POS_W'(cur_line_q);
	assign cc16 = POS_W'(cur_col_q);
	assign tl16 = POS_W'(tok_line_q);
	assign tc16 = POS_W'(tok_col_q);

	assign is_dig   = (text_byte >= "0") && (text_byte <= "9");
	assign is_alpha = ((text_byte >= "a") && (text_byte <= "z")) ||
		((text_byte >= "A") && (text_byte <= "Z"));
	assign id_start = is_alpha || (text_byte == CH_UNDER);
	assign id_char  = id_start || is_dig;
	assign is_blank = text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
	assign is_punct = text_byte inside {CH_EQUAL, CH_COMMA, CH_DOT, CH_LBRK, CH_RBRK};

	always_comb begin
		case (text_byte)
			CH_EQUAL: punct_tok = TK_EQUAL;
			CH_COMMA: punct_tok = TK_COMMA;
			CH_DOT:   punct_tok = TK_DOT;
			CH_LBRK:  punct_tok = TK_LBRACKET;
			default:  punct_tok = TK_RBRACKET;
		endcase
	end

	always_comb begin
		case (kw_q)
			KW_DO:   kw_tok = TK_DO;
			KW_END:  kw_tok = TK_END;
			default: kw_tok = TK_IDENT;
		endcase
	end

	always_comb begin
		if (kw_q == KW_D && text_byte == "o") kw_step = KW_DO;
		else if (kw_q == KW_E && text_byte == "n") kw_step = KW_EN;
		else if (kw_q == KW_EN && text_byte == "d") kw_step = KW_END;
		else kw_step = KW_NONE;
	end

	always_comb begin
		p          = '0;
		m1         = '0;
		m2         = '0;
		p_en       = 1'b0;
		m1_en      = 1'b0;
		m2_en      = 1'b0;
		mode_d     = mode_q;
		kw_d       = kw_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		do_idle    = 1'b0;
		adv        = 1'b0;
		if (is_end) begin
			case (mode_q)
				MD_IDENT: begin
					p_en   = 1'b1;
					p      = mk_tok(kw_tok, tl16, tc16);
					m1_en  = 1'b1;
					m1     = mk_tok(TK_EOF, cl16, cc16);
					mode_d = MD_DONE;
				end
				MD_NUM_INT, MD_NUM_FRAC: begin
					p_en   = 1'b1;
					p      = mk_tok(TK_NUMBER, tl16, tc16);
					m1_en  = 1'b1;
					m1     = mk_tok(TK_EOF, cl16, cc16);
					mode_d = MD_DONE;
				end
				MD_NUM_DOT: begin
					m1_en  = 1'b1;
					m1     = mk_err(ER_NUMBER, cl16, cc16);
					mode_d = MD_ERROR;
				end
				MD_STR, MD_STR_ESC: begin
					m1_en  = 1'b1;
					m1     = mk_err(ER_UNTERM, tl16, tc16);
					mode_d = MD_ERROR;
				end
				MD_ERROR: begin
				end
				default: begin
					m1_en  = 1'b1;
					m1     = mk_tok(TK_EOF, cl16, cc16);
					mode_d = MD_DONE;
				end
			endcase
		end else begin
			adv = (mode_q != MD_DONE) && (mode_q != MD_ERROR);
			case (mode_q)
				MD_COMMENT: begin
					if (text_byte == CH_LF) mode_d = MD_IDLE;
				end
				MD_IDENT: begin
					if (id_char) begin
						kw_d  = kw_step;
						m1_en = 1'b1;
						m1    = mk_lex(text_byte, cl16, cc16);
					end else begin
						p_en    = 1'b1;
						p       = mk_tok(kw_tok, tl16, tc16);
						do_idle = 1'b1;
					end
				end
				MD_NUM_INT: begin
					if (is_dig) begin
						m1_en = 1'b1;
						m1    = mk_lex(text_byte, cl16, cc16);
					end else if (text_byte == CH_DOT) begin
						m1_en  = 1'b1;
						m1     = mk_lex(text_byte, cl16, cc16);
						mode_d = MD_NUM_DOT;
					end else begin
						p_en    = 1'b1;
						p       = mk_tok(TK_NUMBER, tl16, tc16);
						do_idle = 1'b1;
					end
				end
				MD_NUM_DOT: begin
					m1_en = 1'b1;
					if (is_dig) begin
						m1     = mk_lex(text_byte, cl16, cc16);
						mode_d = MD_NUM_FRAC;
					end else begin
						m1     = mk_err(ER_NUMBER, cl16, cc16);
						mode_d = MD_ERROR;
					end
				end
				MD_NUM_FRAC: begin
					if (is_dig) begin
						m1_en = 1'b1;
						m1    = mk_lex(text_byte, cl16, cc16);
					end else begin
						p_en    = 1'b1;
						p       = mk_tok(TK_NUMBER, tl16, tc16);
						do_idle = 1'b1;
					end
				end
				MD_STR: begin
					if (text_byte == CH_DQUOTE) begin
						m1_en  = 1'b1;
						m1     = mk_tok(TK_STRING, tl16, tc16);
						mode_d = MD_IDLE;
					end else if (text_byte == CH_BSLASH) begin
						mode_d = MD_STR_ESC;
					end else begin
						m1_en = 1'b1;
						m1    = mk_lex(text_byte, cl16, cc16);
					end
				end
				MD_STR_ESC: begin
					m1_en  = 1'b1;
					mode_d = MD_STR;
					if (text_byte == CH_DQUOTE || text_byte == CH_BSLASH) begin
						m1 = mk_lex(text_byte, cl16, cc16);
					end else if (text_byte == "n") begin
						m1 = mk_lex(CH_LF, cl16, cc16);
					end else if (text_byte == "t") begin
						m1 = mk_lex(CH_TAB, cl16, cc16);
					end else begin
						m1     = mk_err(ER_ESCAPE, cl16, cc16);
						mode_d = MD_ERROR;
					end
				end
				MD_IDLE: begin
					do_idle = 1'b1;
				end
				default: begin
				end
			endcase
			if (do_idle) begin
				mode_d = MD_IDLE;
				if (is_blank) begin
				end else if (text_byte == CH_HASH) begin
					mode_d = MD_COMMENT;
				end else if (id_start) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
					kw_d       = (text_byte == "d") ? KW_D : ((text_byte == "e") ? KW_E : KW_NONE);
					mode_d     = MD_IDENT;
					m1_en      = 1'b1;
					m1         = mk_lex(text_byte, cl16, cc16);
				end else if (is_dig || text_byte == CH_MINUS) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
					mode_d     = MD_NUM_INT;
					m1_en      = 1'b1;
					m1         = mk_lex(text_byte, cl16, cc16);
				end else if (text_byte == CH_DQUOTE) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
					mode_d     = MD_STR;
				end else if (text_byte == CH_SQUOTE) begin
					m1_en  = 1'b1;
					m1     = mk_err(ER_SQUOTE, cl16, cc16);
					mode_d = MD_ERROR;
				end else if (is_punct) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
					m1_en      = 1'b1;
					m1         = mk_lex(text_byte, cl16, cc16);
					m2_en      = 1'b1;
					m2         = mk_tok(punct_tok, cl16, cc16);
				end else begin
					m1_en  = 1'b1;
					m1     = mk_err(ER_CHAR, cl16, cc16);
					mode_d = MD_ERROR;
				end
			end
		end
	end

	always_comb begin
		push_data.cnt     = 2'({1'b0, p_en}) + 2'({1'b0, m1_en}) + 2'({1'b0, m2_en});
		push_data.recs[0] = p_en ? p : m1;
		push_data.recs[1] = p_en ? m1 : m2;
		push_data.recs[2] = m2;
	end

	assign push_valid = acc && (push_data.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MD_IDLE;
			kw_q       <= KW_NONE;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COLUMN_BITS'(1);
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COLUMN_BITS'(1);
		end else if (acc) begin
			mode_q     <= mode_d;
			kw_q       <= kw_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			if (adv) begin
				if (text_byte == CH_LF) begin
					if (cur_line_q != '1) cur_line_q <= cur_line_q + LINE_BITS'(1);
					cur_col_q <= COLUMN_BITS'(1);
				end else if (cur_col_q != '1) begin
					cur_col_q <= cur_col_q + COLUMN_BITS'(1);
				end
			end
		end
	end

endmodule

[hw/rtl/cfgtok_queue.sv]
module cfgtok_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  cfgtok_pkg::bundle_t  push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output cfgtok_pkg::bundle_t  head
);
	import cfgtok_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_valid) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_valid) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push_valid && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push_valid) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

[hw/rtl/cfgtok_back.sv]
module cfgtok_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  cfgtok_pkg::bundle_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           record_kind,
	output logic [7:0]           lexeme_byte,
	output logic [3:0]           token_kind,
	output logic [2:0]           error_code,
	output logic [15:0]          line_number,
	output logic [15:0]          column_number,
	output logic                 last_of_item
);
	import cfgtok_pkg::*;

	logic [1:0] idx_q;
	rec_t       cur;
	logic       acc;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.recs[0];
			2'd1:    cur = head.recs[1];
			default: cur = head.recs[2];
		endcase
	end

	assign out_valid     = ~empty;
	assign acc           = out_valid & ~out_stall;
	assign last_of_item  = (idx_q == head.cnt - 2'd1);
	assign pop           = acc & last_of_item;
	assign record_kind   = cur.kind;
	assign lexeme_byte   = cur.lbyte;
	assign token_kind    = cur.tok;
	assign error_code    = cur.err;
	assign line_number   = cur.line;
	assign column_number = cur.col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (acc) begin
			idx_q <= last_of_item ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[hw/rtl/config_text_tokenizer.sv]
// an accepted item's results are registered in the queue and offered from there
// one input item per cycle unless the queue is full; the output sends one result
// per cycle unless out_stall is high, so an item with two or three results is a burst
// a queue of QUEUE_DEPTH items between scanner and output absorbs those bursts
// reset: asynchronous, scanner between tokens at line 1 column 1, queue empty
module config_text_tokenizer #(
	parameter int LINE_BITS   = cfgtok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = cfgtok_pkg::COLUMN_BITS_DEF,
	parameter int QUEUE_DEPTH = cfgtok_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        is_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [7:0]  lexeme_byte,
	output logic [3:0]  token_kind,
	output logic [2:0]  error_code,
	output logic [15:0] line_number,
	output logic [15:0] column_number,
	output logic        last_of_item
);
	import cfgtok_pkg::*;

	logic    push_valid, full, empty, pop;
	bundle_t push_data, head;

	assign in_stall = full;

	cfgtok_front #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.text_byte  (text_byte),
		.is_end     (is_end),
		.full       (full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	cfgtok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	cfgtok_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.record_kind   (record_kind),
		.lexeme_byte   (lexeme_byte),
		.token_kind    (token_kind),
		.error_code    (error_code),
		.line_number   (line_number),
		.column_number (column_number),
		.last_of_item  (last_of_item)
	);

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == RK_ERROR |-> last_of_item)
		else $error("error record not last of its item");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == RK_TOKEN && token_kind == TK_EOF |-> last_of_item)
		else $error("eof token not last of its item");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && record_kind == RK_ERROR |=> !out_valid)
		else $error("result after error record");

	a_lex_only_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind != RK_LEX |-> lexeme_byte == 8'd0)
		else $error("lexeme byte set on non-lexeme record");

endmodule

[tb/config_text_tokenizer_tb.sv]
`timescale 1ns / 100ps

module config_text_tokenizer_tb;
	import cfgtok_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_AFTER = 60;
	localparam int LONG_HOLD = 150;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [2:0] KW_NONE = 3'd0;
	localparam logic [2:0] KW_D = 3'd1;
	localparam logic [2:0] KW_DO = 3'd2;
	localparam logic [2:0] KW_E = 3'd3;
	localparam logic [2:0] KW_EN = 3'd4;
	localparam logic [2:0] KW_END = 3'd5;

	localparam string IDENT_CHARS =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_NUM_INT, SCAN_NUM_DOT, SCAN_NUM_FRAC,
		SCAN_STR, SCAN_STR_ESC, SCAN_DONE, SCAN_ERROR
	} scan_mode_e;

	typedef enum {FR_IDENT, FR_NUMBER, FR_STRING, FR_PUNCT, FR_BLANK, FR_COMMENT, FR_NOISE}
		frag_kind_e;

	typedef enum {STALL_NONE, STALL_PATTERN, STALL_HEAVY} stall_mode_e;

	typedef struct {
		scan_mode_e  mode;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] tok_line;
		logic [15:0] tok_col;
		logic [2:0]  kw;
	} scan_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  lbyte;
		logic [3:0]  tok;
		logic [2:0]  err;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} lex_record_t;

	class lexer_tracker;
		scan_state_t state;
		lex_record_t pending_records[$];
		lex_record_t step_out[3];
		int step_count;
		int mismatches;

		function new();
			state = reset_state();
			step_count = 0;
			mismatches = 0;
		endfunction

		function scan_state_t reset_state();
			scan_state_t s;
			s.mode = SCAN_IDLE;
			s.line = 16'd1;
			s.col = 16'd1;
			s.tok_line = 16'd1;
			s.tok_col = 16'd1;
			s.kw = KW_NONE;
			return s;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_ident_start(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
		endfunction

		function void put(logic [1:0] kind, logic [7:0] b, logic [3:0] tok, logic [2:0] err,
				logic [15:0] line, logic [15:0] col);
			lex_record_t r;
			if (step_count >= 3)
				return;
			r.kind = kind;
			r.lbyte = b;
			r.tok = tok;
			r.err = err;
			r.line = line;
			r.col = col;
			r.last = 1'b0;
			step_out[step_count] = r;
			step_count++;
		endfunction

		function void put_lex(inout scan_state_t s, input logic [7:0] b);
			put(RK_LEX, b, '0, '0, s.line, s.col);
		endfunction

		function void put_tok(inout scan_state_t s, input logic [3:0] t);
			put(RK_TOKEN, '0, t, '0, s.tok_line, s.tok_col);
		endfunction

		function void put_err(inout scan_state_t s, input logic [2:0] e,
				input logic [15:0] line, input logic [15:0] col);
			put(RK_ERROR, '0, '0, e, line, col);
			s.mode = SCAN_ERROR;
		endfunction

		function void finish_ident(inout scan_state_t s);
			if (s.kw == KW_DO)
				put_tok(s, TK_DO);
			else if (s.kw == KW_END)
				put_tok(s, TK_END);
			else
				put_tok(s, TK_IDENT);
			s.mode = SCAN_IDLE;
		endfunction

		function void idle_byte(inout scan_state_t s, input logic [7:0] b);
			logic [3:0] t;
			if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF)
				return;
			if (b == CH_HASH) begin
				s.mode = SCAN_COMMENT;
				return;
			end
			if (is_ident_start(b)) begin
				s.tok_line = s.line;
				s.tok_col = s.col;
				s.kw = (b == "d") ? KW_D : ((b == "e") ? KW_E : KW_NONE);
				s.mode = SCAN_IDENT;
				put_lex(s, b);
				return;
			end
			if (b == CH_MINUS || is_digit(b)) begin
				s.tok_line = s.line;
				s.tok_col = s.col;
				s.mode = SCAN_NUM_INT;
				put_lex(s, b);
				return;
			end
			if (b == CH_QUOTE) begin
				s.tok_line = s.line;
				s.tok_col = s.col;
				s.mode = SCAN_STR;
				return;
			end
			if (b == CH_SQUOTE) begin
				put_err(s, ER_SQUOTE, s.line, s.col);
				return;
			end
			case (b)
				CH_EQUAL: t = TK_EQUAL;
				CH_COMMA: t = TK_COMMA;
				CH_DOT: t = TK_DOT;
				CH_LBRACK: t = TK_LBRACKET;
				CH_RBRACK: t = TK_RBRACKET;
				default: begin
					put_err(s, ER_CHAR, s.line, s.col);
					return;
				end
			endcase
			s.tok_line = s.line;
			s.tok_col = s.col;
			put_lex(s, b);
			put_tok(s, t);
		endfunction

		function void scan_byte(inout scan_state_t s, input logic [7:0] b);
			bit restart;
			restart = 1'b0;
			case (s.mode)
				SCAN_IDLE: restart = 1'b1;
				SCAN_COMMENT: if (b == CH_LF) s.mode = SCAN_IDLE;
				SCAN_IDENT: begin
					if (is_ident_start(b) || is_digit(b)) begin
						if (s.kw == KW_D && b == "o")
							s.kw = KW_DO;
						else if (s.kw == KW_E && b == "n")
							s.kw = KW_EN;
						else if (s.kw == KW_EN && b == "d")
							s.kw = KW_END;
						else
							s.kw = KW_NONE;
						put_lex(s, b);
					end else begin
						finish_ident(s);
						restart = 1'b1;
					end
				end
				SCAN_NUM_INT: begin
					if (is_digit(b)) begin
						put_lex(s, b);
					end else if (b == CH_DOT) begin
						s.mode = SCAN_NUM_DOT;
						put_lex(s, b);
					end else begin
						put_tok(s, TK_NUMBER);
						s.mode = SCAN_IDLE;
						restart = 1'b1;
					end
				end
				SCAN_NUM_DOT: begin
					if (is_digit(b)) begin
						s.mode = SCAN_NUM_FRAC;
						put_lex(s, b);
					end else begin
						put_err(s, ER_NUMBER, s.line, s.col);
					end
				end
				SCAN_NUM_FRAC: begin
					if (is_digit(b)) begin
						put_lex(s, b);
					end else begin
						put_tok(s, TK_NUMBER);
						s.mode = SCAN_IDLE;
						restart = 1'b1;
					end
				end
				SCAN_STR: begin
					if (b == CH_QUOTE) begin
						put_tok(s, TK_STRING);
						s.mode = SCAN_IDLE;
					end else if (b == CH_BSLASH) begin
						s.mode = SCAN_STR_ESC;
					end else begin
						put_lex(s, b);
					end
				end
				SCAN_STR_ESC: begin
					if (b == CH_QUOTE || b == CH_BSLASH) begin
						put_lex(s, b);
					end else if (b == "n") begin
						put_lex(s, CH_LF);
					end else if (b == "t") begin
						put_lex(s, CH_TAB);
					end else begin
						put_err(s, ER_ESCAPE, s.line, s.col);
						return;
					end
					s.mode = SCAN_STR;
				end
				default: ;
			endcase
			if (restart)
				idle_byte(s, b);
		endfunction

		function void scan_item(inout scan_state_t s, input logic [7:0] b, input logic fin);
			if (s.mode == SCAN_ERROR)
				return;
			if (fin) begin
				case (s.mode)
					SCAN_IDENT: finish_ident(s);
					SCAN_NUM_INT, SCAN_NUM_FRAC: put_tok(s, TK_NUMBER);
					SCAN_NUM_DOT: begin
						put_err(s, ER_NUMBER, s.line, s.col);
						return;
					end
					SCAN_STR, SCAN_STR_ESC: begin
						put_err(s, ER_UNTERM, s.tok_line, s.tok_col);
						return;
					end
					default: ;
				endcase
				put(RK_TOKEN, '0, TK_EOF, '0, s.line, s.col);
				s.mode = SCAN_DONE;
			end else if (s.mode != SCAN_DONE) begin
				scan_byte(s, b);
				// position moves after the byte is classified, saturating
				if (b == CH_LF) begin
					if (s.line != 16'hFFFF)
						s.line = s.line + 16'd1;
					s.col = 16'd1;
				end else if (s.col != 16'hFFFF) begin
					s.col = s.col + 16'd1;
				end
			end
		endfunction

		function void lex_step(inout scan_state_t s, input logic [7:0] b, input logic fin);
			step_count = 0;
			scan_item(s, b, fin);
			if (step_count > 0)
				step_out[step_count - 1].last = 1'b1;
		endfunction

		function void note_request(logic [7:0] b, logic fin);
			lex_step(state, b, fin);
			for (int i = 0; i < step_count; i++)
				pending_records.insert(pending_records.size(), step_out[i]);
		endfunction

		function string describe(lex_record_t r);
			return $sformatf("kind=%0d byte=%02h tok=%0d err=%0d pos=%0d:%0d last=%0d",
				r.kind, r.lbyte, r.tok, r.err, r.line, r.col, r.last);
		endfunction

		function void check_record(lex_record_t got);
			lex_record_t want;
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: %s", describe(got));
				return;
			end
			want = pending_records.pop_front();
			if (got.kind !== want.kind || got.lbyte !== want.lbyte || got.tok !== want.tok ||
					got.err !== want.err || got.line !== want.line || got.col !== want.col ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("record mismatch: expected %s, got %s", describe(want),
						describe(got));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = '0;
	logic        is_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  record_kind;
	logic [7:0]  lexeme_byte;
	logic [3:0]  token_kind;
	logic [2:0]  error_code;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic        last_of_item;

	lexer_tracker tracker = new();
	scan_state_t plan;
	logic [7:0] frag[$];
	int burst_left = 0;
	int items_sent = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned cycle_count = 0;

	config_text_tokenizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.is_end(is_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_kind(record_kind),
		.lexeme_byte(lexeme_byte),
		.token_kind(token_kind),
		.error_code(error_code),
		.line_number(line_number),
		.column_number(column_number),
		.last_of_item(last_of_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("config_text_tokenizer_tb failed");
			$finish;
		end
	end

	// requests are noted before results so a same-edge result finds its expectation
	always @(posedge clk) begin
		lex_record_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_request(text_byte, is_end);
			if (out_valid && !out_stall) begin
				got.kind = record_kind;
				got.lbyte = lexeme_byte;
				got.tok = token_kind;
				got.err = error_code;
				got.line = line_number;
				got.col = column_number;
				got.last = last_of_item;
				tracker.check_record(got);
			end
		end
	end

	initial begin
		logic [15:0] pattern;
		stall_mode_e mode;
		int left;
		int idx;
		pattern = '0;
		mode = STALL_NONE;
		left = 0;
		idx = 0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = stall_mode_e'($urandom_range(0, 2));
					pattern = 16'($urandom_range(0, 16'hFFFF));
					left = 16 * $urandom_range(1, 8);
				end
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_PATTERN: out_stall <= pattern[idx];
					default: out_stall <= pattern[idx] | pattern[(idx + 1) % 16];
				endcase
				idx = (idx + 1) % 16;
				left--;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		tracker.lex_step(plan, b, fin);
		in_valid <= 1'b1;
		text_byte <= b;
		is_end <= fin;
		items_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_frag();
		foreach (frag[i])
			send_item(frag[i], 1'b0);
	endtask

	function automatic void add_byte(logic [7:0] b);
		frag.insert(frag.size(), b);
	endfunction

	function automatic void push_text(string t);
		for (int i = 0; i < t.len(); i++)
			add_byte(t[i]);
	endfunction

	function automatic frag_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return FR_IDENT;
		if (r < 45)
			return FR_NUMBER;
		if (r < 60)
			return FR_STRING;
		if (r < 75)
			return FR_PUNCT;
		if (r < 88)
			return FR_BLANK;
		if (r < 95)
			return FR_COMMENT;
		return FR_NOISE;
	endfunction

	function automatic void make_frag(frag_kind_e kind);
		logic [7:0] b;
		int n;
		frag.delete();
		case (kind)
			FR_IDENT: begin
				case ($urandom_range(0, 6))
					0: push_text("do");
					1: push_text("end");
					2: push_text("d");
					3: push_text("e");
					4: push_text("en");
					default: add_byte(IDENT_CHARS[$urandom_range(0, 52)]);
				endcase
				n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
				repeat (n) add_byte(IDENT_CHARS[$urandom_range(0, 62)]);
			end
			FR_NUMBER: begin
				if ($urandom_range(0, 2) == 0)
					add_byte(CH_MINUS);
				n = $urandom_range((frag.size() == 0) ? 1 : 0, 4);
				repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 2) == 0) begin
					add_byte(CH_DOT);
					repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
				end
			end
			FR_STRING: begin
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 3) == 0) begin
						add_byte(CH_BSLASH);
						case ($urandom_range(0, 3))
							0: add_byte(CH_QUOTE);
							1: add_byte(CH_BSLASH);
							2: add_byte("n");
							default: add_byte("t");
						endcase
					end else begin
						b = 8'($urandom_range(0, 255));
						if (b != CH_QUOTE && b != CH_BSLASH)
							add_byte(b);
					end
				end
				add_byte(CH_QUOTE);
			end
			FR_PUNCT: begin
				case ($urandom_range(0, 4))
					0: add_byte(CH_EQUAL);
					1: add_byte(CH_COMMA);
					2: add_byte(CH_DOT);
					3: add_byte(CH_LBRACK);
					default: add_byte(CH_RBRACK);
				endcase
			end
			FR_BLANK: begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0: add_byte(CH_SP);
						1: add_byte(CH_TAB);
						2: add_byte(CH_CR);
						default: add_byte(CH_LF);
					endcase
				end
			end
			FR_COMMENT: begin
				add_byte(CH_HASH);
				repeat ($urandom_range(0, 10)) begin
					b = 8'($urandom_range(0, 255));
					if (b != CH_LF)
						add_byte(b);
				end
				add_byte(CH_LF);
			end
			default: add_byte(8'($urandom_range(0, 255)));
		endcase
	endfunction

	// a fragment is kept only if it leaves the text free of errors
	function automatic bit frag_fits();
		scan_state_t s;
		s = plan;
		foreach (frag[i]) begin
			tracker.lex_step(s, frag[i], 1'b0);
			if (s.mode == SCAN_ERROR)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_random_fragment();
		do
			make_frag(pick_kind());
		while (!frag_fits());
		send_frag();
	endtask

	task automatic settle_idle();
		while (plan.mode != SCAN_IDLE)
			send_random_fragment();
	endtask

	task automatic finish_text();
		logic [7:0] b;
		scan_state_t s;
		frag.delete();
		case ($urandom_range(0, 7))
			0: ;
			1: push_text("end");
			2: push_text("-3.25");
			3: begin
				push_text("\"ab");
				if ($urandom_range(0, 1))
					add_byte(CH_BSLASH);
			end
			4: push_text("\"a\\q");
			5: add_byte(CH_SQUOTE);
			6: begin
				do begin
					b = 8'($urandom_range(0, 255));
					s = plan;
					tracker.lex_step(s, b, 1'b0);
				end while (s.mode != SCAN_ERROR || b == CH_SQUOTE);
				add_byte(b);
			end
			default: begin
				push_text("7.");
				if ($urandom_range(0, 1))
					add_byte("x");
			end
		endcase
		send_frag();
		send_item(8'($urandom_range(0, 255)), 1'b1);
		// after the end or an error nothing more may come out but a repeated eof
		repeat ($urandom_range(3, 6))
			send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		plan = tracker.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keywords, lone minus, all escapes, fraction, comment with extreme bytes
		frag.delete();
		push_text("do end=-,\"");
		push_text("\\\\\\\"\\n\\t\"[9.05]#");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_LF);
		send_frag();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > HOLD_AFTER)
				hold_req = 1'b1;
			send_random_fragment();
		end

		settle_idle();
		finish_text();
		in_valid <= 1'b0;

		while (tracker.pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("config_text_tokenizer_tb passed");
		else
			$display("config_text_tokenizer_tb failed");
		$finish;
	end

endmodule
